FILE: design/star_record_decode_filter_top_assert.svh
// Assertion helpers used by the checker file.
`ifndef STAR_RECORD_DECODE_FILTER_TOP_ASSERT_SVH
`define STAR_RECORD_DECODE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRDF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/srdf_pkg.sv
`timescale 1ns / 1ps
package srdf_pkg;

  localparam int RECORD_BYTES = 12;
  localparam int POS_W        = $clog2(RECORD_BYTES);
  localparam int HOLD_W       = (RECORD_BYTES - 1) * 8;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // config register indexes
  localparam logic [2:0] CFG_RA_FIRST    = 3'd0;
  localparam logic [2:0] CFG_RA_LAST     = 3'd1;
  localparam logic [2:0] CFG_DEC_FIRST   = 3'd2;
  localparam logic [2:0] CFG_DEC_LAST    = 3'd3;
  localparam logic [2:0] CFG_MAG_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_EXCLUDE_GSC = 3'd5;

  // magnitude word decode
  localparam logic [30:0] MAG_WORD_LIMIT = 31'd1000000000;
  localparam logic [9:0]  DIV_BASE       = 10'd1000;
  localparam logic [9:0]  COLOR_MAX      = 10'd250;
  // floor(x/1000) = ((x >> 3) * RECIP) >> RECIP_SHIFT, exact for x < 2^30
  localparam logic [27:0] RECIP          = 28'd137438954;
  localparam int          RECIP_SHIFT    = 34;

  typedef enum logic [2:0] {
    RSN_OK     = 3'd0,
    RSN_GSC    = 3'd1,
    RSN_POOR   = 3'd2,
    RSN_COLOR  = 3'd3,
    RSN_WINDOW = 3'd4
  } reason_t;

  typedef struct packed {
    logic [31:0] ra;
    logic [31:0] dec;
    logic [31:0] mag;
  } record_t;

  typedef struct packed {
    logic [31:0] ra_first;
    logic [31:0] ra_last;
    logic [31:0] dec_first;
    logic [31:0] dec_last;
    logic [7:0]  mag_limit;
    logic        exclude_gsc;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    reason_t     reason;
    logic [31:0] ra_units;
    logic [31:0] dec_units;
    logic [7:0]  mag_tenths;
    logic        is_gsc;
    logic        past_end;
  } result_t;

endpackage

FILE: design/srdf_if.sv
`timescale 1ns / 1ps
// byte stream channel
interface srdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source(output valid, data_byte, record_start, input ready);
  modport sink(input valid, data_byte, record_start, output ready);
endinterface

// decoded record channel
interface srdf_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  reason;
  logic [31:0] ra_units;
  logic [31:0] dec_units;
  logic [7:0]  mag_tenths;
  logic        is_gsc;
  logic        past_end;

  modport source(output valid, accepted, reason, ra_units, dec_units, mag_tenths,
                 is_gsc, past_end, input ready);
  modport sink(input valid, accepted, reason, ra_units, dec_units, mag_tenths,
               is_gsc, past_end, output ready);
endinterface

FILE: design/star_record_decode_filter_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Transaction                       Fields
// in_ch     in   one catalog byte                  data_byte[7:0], record_start
// out_ch    out  one decoded record per 12 bytes   accepted, reason[2:0], ra_units,
//                                                  dec_units, mag_tenths, is_gsc, past_end
// cfg_*     in   register write, no read-back      cfg_we, cfg_index[2:0], cfg_wdata[31:0]
//
// One byte per cycle while in_ch is not held off. A record result passes through
// the queue head, two multiply stages and the output register; records are twelve
// bytes long, so the back pipeline limits the byte rate only while out_ch stalls.
// Reset (rst_n low, synchronous) clears byte position, queue, stage valids and
// loads the register reset values; no clearing pass is needed.
// A stalled out_ch fills the output register, the two stages and the 2-entry
// queue; only then is the final byte of the next record held off in_ch.
module star_record_decode_filter_top import srdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  srdf_in_if.sink     in_ch,
  srdf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    q_full, push, pop, head_valid;
  record_t push_rec, head;
  result_t res;

  // Configuration bank. Writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ra_first    <= 32'd0;
      cfg_r.ra_last     <= 32'hFFFF_FFFF;
      cfg_r.dec_first   <= 32'd0;
      cfg_r.dec_last    <= 32'hFFFF_FFFF;
      cfg_r.mag_limit   <= 8'd255;
      cfg_r.exclude_gsc <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RA_FIRST:    cfg_r.ra_first    <= cfg_wdata;
        CFG_RA_LAST:     cfg_r.ra_last     <= cfg_wdata;
        CFG_DEC_FIRST:   cfg_r.dec_first   <= cfg_wdata;
        CFG_DEC_LAST:    cfg_r.dec_last    <= cfg_wdata;
        CFG_MAG_LIMIT:   cfg_r.mag_limit   <= cfg_wdata[7:0];
        CFG_EXCLUDE_GSC: cfg_r.exclude_gsc <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: shift bytes in, hand each complete record to the queue.
  srdf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (in_ch.valid),
    .byte_ready   (in_ch.ready),
    .data_byte    (in_ch.data_byte),
    .record_start (in_ch.record_start),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  // Decouples the byte side from the decode side.
  srdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: mark handling, /1000 by reciprocal, color choice, window test.
  srdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg_r),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.accepted   = res.accepted;
  assign out_ch.reason     = res.reason;
  assign out_ch.ra_units   = res.ra_units;
  assign out_ch.dec_units  = res.dec_units;
  assign out_ch.mag_tenths = res.mag_tenths;
  assign out_ch.is_gsc     = res.is_gsc;
  assign out_ch.past_end   = res.past_end;

endmodule

FILE: design/srdf_front.sv
`timescale 1ns / 1ps
module srdf_front import srdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  input  logic       q_full,
  output logic       push,
  output record_t    push_rec
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HOLD_W-1:0] hold_r;
  logic [POS_W-1:0]  eff_pos;
  logic              take;

  // last byte of a record waits for queue room
  assign byte_ready = !((pos_r == LAST_POS) && q_full);
  assign take       = byte_valid && byte_ready;
  assign eff_pos    = record_start ? '0 : pos_r;
  assign push       = take && (eff_pos == LAST_POS);
  assign push_rec   = record_t'({hold_r, data_byte});

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = (eff_pos == LAST_POS) ? '0 : eff_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // oldest byte ends up in the top bits; stale bytes shift out
  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= {hold_r[HOLD_W-9:0], data_byte};
    end
  end

endmodule

FILE: design/srdf_queue.sv
`timescale 1ns / 1ps
module srdf_queue import srdf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  record_t push_rec,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output record_t head
);

  record_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: design/srdf_back.sv
`timescale 1ns / 1ps
module srdf_back import srdf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  record_t head,
  output logic    pop,
  input  cfg_t    cfg,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  // stage 1: reciprocal product for the first /1000
  logic        v1_r;
  logic [31:0] ra1_r, dec1_r;
  logic        gsc1_r, excl1_r, poor1_r;
  logic [29:0] low1_r;
  logic [54:0] prod1_r;

  // stage 2: red digits and product for the second /1000
  logic        v2_r;
  logic [31:0] ra2_r, dec2_r;
  logic        gsc2_r, excl2_r, poor2_r;
  logic [9:0]  red2_r;
  logic [20:0] q1_2_r;
  logic [45:0] prod2_r;

  // output register
  logic        vo_r;
  result_t     res_r;

  logic        en_a, en_b, en_c;
  logic [54:0] prod1_a;
  logic [20:0] q1_b;
  logic [29:0] rem_b;
  logic [45:0] prod2_b;

  logic [11:0] q2_c;
  logic [20:0] rem_c;
  logic [9:0]  blu_c;
  logic [7:0]  chosen_c;
  logic        in_window_c;
  reason_t     reason_c;
  result_t     res_c;

  assign en_c = !vo_r || res_ready;
  assign en_b = !v2_r || en_c;
  assign en_a = !v1_r || en_b;
  assign pop  = en_a && head_valid;

  assign prod1_a = 55'(head.mag[29:3]) * 55'(RECIP);

  assign q1_b    = prod1_r[RECIP_SHIFT +: 21];
  assign rem_b   = low1_r - (30'(q1_b) * 30'(DIV_BASE));
  assign prod2_b = 46'(q1_b[20:3]) * 46'(RECIP);

  always_comb begin
    q2_c        = prod2_r[RECIP_SHIFT +: 12];
    rem_c       = q1_2_r - (21'(q2_c) * 21'(DIV_BASE));
    blu_c       = rem_c[9:0];
    chosen_c    = (red2_r <= COLOR_MAX) ? red2_r[7:0] : blu_c[7:0];
    in_window_c = (chosen_c <= cfg.mag_limit) &&
                  (ra2_r >= cfg.ra_first) && (ra2_r <= cfg.ra_last) &&
                  (dec2_r >= cfg.dec_first) && (dec2_r <= cfg.dec_last);
    priority if (excl2_r) begin
      reason_c = RSN_GSC;
    end else if (poor2_r) begin
      reason_c = RSN_POOR;
    end else if ((red2_r > COLOR_MAX) && (blu_c > COLOR_MAX)) begin
      reason_c = RSN_COLOR;
    end else if (!in_window_c) begin
      reason_c = RSN_WINDOW;
    end else begin
      reason_c = RSN_OK;
    end
    res_c.accepted   = (reason_c == RSN_OK);
    res_c.reason     = reason_c;
    res_c.ra_units   = ra2_r;
    res_c.dec_units  = dec2_r;
    res_c.mag_tenths = (reason_c == RSN_OK) ? chosen_c : 8'd0;
    res_c.is_gsc     = gsc2_r;
    res_c.past_end   = (ra2_r > cfg.ra_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_a) begin
        v1_r <= head_valid;
      end
      if (en_b) begin
        v2_r <= v1_r;
      end
      if (en_c) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ra1_r   <= head.ra;
      dec1_r  <= head.dec;
      gsc1_r  <= head.mag[31];
      excl1_r <= head.mag[31] && cfg.exclude_gsc;
      poor1_r <= (head.mag[30:0] >= MAG_WORD_LIMIT);
      low1_r  <= head.mag[29:0];
      prod1_r <= prod1_a;
    end
    if (en_b) begin
      ra2_r   <= ra1_r;
      dec2_r  <= dec1_r;
      gsc2_r  <= gsc1_r;
      excl2_r <= excl1_r;
      poor2_r <= poor1_r;
      red2_r  <= rem_b[9:0];
      q1_2_r  <= q1_b;
      prod2_r <= prod2_b;
    end
    if (en_c) begin
      res_r <= res_c;
    end
  end

  assign res_valid = vo_r;
  assign res       = res_r;

endmodule

FILE: design/srdf_checker.sv
`timescale 1ns / 1ps
`include "star_record_decode_filter_top_assert.svh"
module srdf_checker import srdf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [2:0]  reason,
  input logic [31:0] ra_units,
  input logic [31:0] dec_units,
  input logic [7:0]  mag_tenths,
  input logic        is_gsc,
  input logic        past_end
);

  // held result transaction keeps its payload
  `SRDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(reason) && $stable(ra_units) && $stable(dec_units) &&
    $stable(mag_tenths) && $stable(is_gsc) && $stable(past_end),
    "stalled result changed")

  // accepted flag, reason code and magnitude agree and stay in range
  `SRDF_ASSERT_IMPLY(a_reason_code, out_valid,
    (accepted == (reason == RSN_OK)) && (reason <= RSN_WINDOW) &&
    (accepted || (mag_tenths == 8'd0)) && (mag_tenths <= 8'd250),
    "inconsistent reason")

  // an accepted record lies inside the RA window, so cannot be past end
  `SRDF_ASSERT_IMPLY(a_accept_not_past, out_valid && accepted, !past_end,
    "accepted record past end")

endmodule

bind star_record_decode_filter_top srdf_checker u_srdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .accepted   (out_ch.accepted),
  .reason     (out_ch.reason),
  .ra_units   (out_ch.ra_units),
  .dec_units  (out_ch.dec_units),
  .mag_tenths (out_ch.mag_tenths),
  .is_gsc     (out_ch.is_gsc),
  .past_end   (out_ch.past_end)
);
